### src/slw_pkg.sv
// ----------------------------------------------------------------------------
// slw_pkg: shared types and constants for the slope limiter window
// Holds the limiter mode encoding and the window fill constants.
// ----------------------------------------------------------------------------
`default_nettype none

package slw_pkg;

   // Limiter selection written through the configuration port.
   typedef enum logic [1:0] {
      MODE_ZERO    = 2'd0,
      MODE_CENTRED = 2'd1,
      MODE_MINMOD  = 2'd2,
      MODE_MC      = 2'd3
   } limiter_mode_type;

   // Number of cells held in the window, 0 to 2.
   typedef logic [1:0] fill_count_type;

   localparam limiter_mode_type MODE_RESET = MODE_MINMOD;
   localparam fill_count_type   FILL_EMPTY = 2'd0;
   localparam fill_count_type   FILL_FULL  = 2'd2;

endpackage

`default_nettype wire

### src/slw_limiter.sv
// ----------------------------------------------------------------------------
// slw_limiter: limited slope of the centre cell of a three-cell window
// Forms the saturated backward, forward and centred differences and applies
// the selected limiter (zero, centred, minmod or monotonized central).
// ----------------------------------------------------------------------------
`default_nettype none

module slw_limiter
   import slw_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic signed [DATA_WIDTH-1:0] left_value,
   input  wire logic signed [DATA_WIDTH-1:0] centre_value,
   input  wire logic signed [DATA_WIDTH-1:0] right_value,
   input  wire limiter_mode_type             limiter_mode,
   output logic signed [DATA_WIDTH-1:0]      slope
);

   localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
   localparam logic [DATA_WIDTH-1:0] ZERO    = '0;

   // Exact difference a - b, saturated to the data width.
   function automatic logic [DATA_WIDTH-1:0] sat_sub(
      input logic [DATA_WIDTH-1:0] a,
      input logic [DATA_WIDTH-1:0] b
   );
      logic [DATA_WIDTH:0] d;
      d = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (d[DATA_WIDTH] != d[DATA_WIDTH-1]) begin
         sat_sub = d[DATA_WIDTH] ? MIN_NEG : MAX_POS;
      end else begin
         sat_sub = d[DATA_WIDTH-1:0];
      end
   endfunction

   // Two's complement negation in the data width.
   function automatic logic [DATA_WIDTH-1:0] negate(input logic [DATA_WIDTH-1:0] v);
      negate = ~v + ONE;
   endfunction

   // Magnitude; the most negative value maps to 2^(W-1) as an unsigned word.
   function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
      magnitude = v[DATA_WIDTH-1] ? negate(v) : v;
   endfunction

   // Twice the magnitude in W bits; a magnitude with its top bit set gives 2^(W-1).
   function automatic logic [DATA_WIDTH-1:0] double_cap(input logic [DATA_WIDTH-1:0] m);
      double_cap = m[DATA_WIDTH-1] ? MIN_NEG : {m[DATA_WIDTH-2:0], 1'b0};
   endfunction

   logic [DATA_WIDTH-1:0] back_diff;
   logic [DATA_WIDTH-1:0] fwd_diff;
   logic [DATA_WIDTH-1:0] cent_diff;
   logic [DATA_WIDTH-1:0] back_mag;
   logic [DATA_WIDTH-1:0] fwd_mag;
   logic [DATA_WIDTH-1:0] cent_mag;
   logic [DATA_WIDTH-1:0] half_cent_mag;
   logic [DATA_WIDTH-1:0] back_dbl;
   logic [DATA_WIDTH-1:0] fwd_dbl;
   logic [DATA_WIDTH-1:0] mc_mag;
   logic                  same_sign;

   // Saturated differences across the window and their magnitudes.
   always_comb begin
      back_diff     = sat_sub(centre_value, left_value);
      fwd_diff      = sat_sub(right_value, centre_value);
      cent_diff     = sat_sub(right_value, left_value);
      back_mag      = magnitude(back_diff);
      fwd_mag       = magnitude(fwd_diff);
      cent_mag      = magnitude(cent_diff);
      half_cent_mag = {1'b0, cent_mag[DATA_WIDTH-1:1]};
      back_dbl      = double_cap(back_mag);
      fwd_dbl       = double_cap(fwd_mag);
      same_sign     = (back_diff != ZERO) && (fwd_diff != ZERO) &&
                      (back_diff[DATA_WIDTH-1] == fwd_diff[DATA_WIDTH-1]);
   end

   // Smallest of the three MC candidates; it never exceeds 2^(W-2).
   always_comb begin
      mc_mag = half_cent_mag;
      if (fwd_dbl < mc_mag) begin
         mc_mag = fwd_dbl;
      end
      if (back_dbl < mc_mag) begin
         mc_mag = back_dbl;
      end
   end

   // Limiter selection.
   always_comb begin
      unique case (limiter_mode)
         MODE_ZERO: begin
            slope = '0;
         end
         MODE_CENTRED: begin
            slope = $signed(cent_diff) >>> 1;
         end
         MODE_MINMOD: begin
            if (!same_sign || (back_mag == fwd_mag)) begin
               slope = '0;
            end else if (back_mag < fwd_mag) begin
               slope = $signed(back_diff);
            end else begin
               slope = $signed(fwd_diff);
            end
         end
         MODE_MC: begin
            if (!same_sign) begin
               slope = '0;
            end else if (cent_diff[DATA_WIDTH-1]) begin
               slope = $signed(negate(mc_mag));
            end else begin
               slope = $signed(mc_mag);
            end
         end
         default: begin
            slope = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/slope_limiter_window.sv
// Path: the item that completes a window is taken into the input register, then
// the limiter logic feeds the result register, from which the result leaves.
// Throughput: one item per cycle; the input register and result register form
// a two-deep pipeline that stalls only when the result side holds back.
// Reset (synchronous, active high) empties the window and the pipeline and
// sets the limiter mode to minmod.
// ----------------------------------------------------------------------------
// slope_limiter_window: streaming TVD slope limiter over three cells
// Keeps the last two samples of a grid line and emits the limited slope of
// the centre cell for every further sample.
// ----------------------------------------------------------------------------
`default_nettype none

module slope_limiter_window
   import slw_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Sample items
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,  // sample
   input  wire logic [0:0]                           req_tuser,  // line_start
   // Slope items
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]           rsp_tdata,  // slope
   // Limiter mode register
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [1:0]                           csr_data
);

   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;

   limiter_mode_type      mode_ff;
   logic [DATA_WIDTH-1:0] left_ff, centre_ff;
   fill_count_type        fill_ff, fill_in, fill_base;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_emit_ff;
   logic [DATA_WIDTH-1:0] s1_left_ff, s1_centre_ff, s1_right_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff;

   logic                  advance;
   logic                  req_fire;
   logic                  line_start;
   logic [DATA_WIDTH-1:0] sample;
   logic signed [DATA_WIDTH-1:0] slope;

   assign sample     = req_tdata[DATA_WIDTH-1:0];
   assign line_start = req_tuser[0];

   // Pipeline handshake: the input register moves on when the result register
   // is empty or being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Limiter mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_valid) begin
         mode_ff <= limiter_mode_type'(csr_data);
      end
   end

   // Window fill count; a line start empties the window first.
   always_comb begin
      fill_base = line_start ? FILL_EMPTY : fill_ff;
      fill_in   = (fill_base == FILL_FULL) ? FILL_FULL : fill_base + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_EMPTY;
      end else if (req_fire) begin
         fill_ff <= fill_in;
      end
   end

   // Window shift on every accepted item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff   <= centre_ff;
         centre_ff <= sample;
      end
   end

   // Input register: the three cells and whether this item yields a slope.
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_emit_ff   <= (fill_base == FILL_FULL);
         s1_left_ff   <= left_ff;
         s1_centre_ff <= centre_ff;
         s1_right_ff  <= sample;
      end
   end

   slw_limiter #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_limiter (
      .left_value   (s1_left_ff),
      .centre_value (s1_centre_ff),
      .right_value  (s1_right_ff),
      .limiter_mode (mode_ff),
      .slope        (slope)
   );

   // Result register.
   always_comb begin
      if (advance) begin
         rsp_valid_in = s1_valid_ff && s1_emit_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_emit_ff) begin
         rsp_data_ff <= slope;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(rsp_data_ff);

endmodule

`default_nettype wire

### src/slw_checker.sv
// ----------------------------------------------------------------------------
// slw_checker: port-level assertions for the slope limiter window
// Watches the top-level ports and is attached by the bind at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module slw_checker #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [0:0]                      req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [((DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready
);

   // A stalled slope item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("slope item changed while stalled");

   // Reset leaves no slope item pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("slope item valid after reset");

   // With the result side empty the block always takes a sample.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("sample refused while result register empty");

   // A sample that starts a line never produces a slope.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |-> ##2 !$rose(rsp_tvalid))
      else $error("slope emitted for the first cell of a line");

   // The mode register never stalls a write.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("mode write stalled");

endmodule

bind slope_limiter_window slw_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_slw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for slope_limiter_window
// A scoreboard class models the three-cell window and the four limiters. It
// queues the expected slope of every sample that fills a window and checks each result
// item in order. Tasks drive directed edge cases, then random grid lines under
// every limiter mode, with random gaps on both sides and one stretch without.
// ----------------------------------------------------------------------------

module tb_top;
   import slw_pkg::*;

   localparam int          DW          = 32;
   localparam longint      SLOPE_MAX   = (longint'(1) <<< (DW - 1)) - 1;
   localparam longint      SLOPE_MIN   = -(longint'(1) <<< (DW - 1));
   localparam int          SETTLE      = 6;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 112;

   // Directed grid lines, six cells each; a new line starts every sixth item
   // and once more within the last line.
   localparam logic [DW-1:0] DIRECTED [0:23] = '{
      32'd0, 32'd10, 32'd20, 32'd25, 32'd100, 32'd90,
      32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000, 32'd1,
      32'd0, 32'd1, 32'd3, 32'd7, 32'h7fffffff, 32'h80000001,
      32'h80000000, 32'd0, 32'h7fffffff, 32'd5, 32'hffffffff, 32'd3
   };

   // Edge values mixed into the random lines.
   localparam logic [DW-1:0] EDGE_VALUES [0:6] = '{
      32'h7fffffff, 32'h80000000, 32'd0, 32'hffffffff, 32'd1, 32'h80000001,
      32'h7ffffffe
   };

   // Window model and queue of expected slopes.
   class slope_scoreboard;
      limiter_mode_type mode;
      logic [DW-1:0]    left_cell;
      logic [DW-1:0]    centre_cell;
      fill_count_type   cells_held;
      logic [DW-1:0]    expected_slopes[$];
      int               errors;

      function new();
         mode        = MODE_RESET;
         left_cell   = '0;
         centre_cell = '0;
         cells_held  = FILL_EMPTY;
         errors      = 0;
      endfunction

      function void set_mode(limiter_mode_type m);
         mode = m;
      endfunction

      static function longint clamp(longint v);
         if (v > SLOPE_MAX) return SLOPE_MAX;
         if (v < SLOPE_MIN) return SLOPE_MIN;
         return v;
      endfunction

      // Doubling of a magnitude, capped at 2^(DW-1).
      static function longint double_capped(longint m);
         if (m >= -SLOPE_MIN) return -SLOPE_MIN;
         return m * 2;
      endfunction

      function logic [DW-1:0] limited_slope(longint l, longint c, longint r);
         longint bk;
         longint fw;
         longint cd;
         longint mb;
         longint mf;
         longint m;
         longint t;
         bit     same;
         bk   = clamp(c - l);
         fw   = clamp(r - c);
         cd   = clamp(r - l);
         same = (bk != 0) && (fw != 0) && ((bk < 0) == (fw < 0));
         mb   = (bk < 0) ? -bk : bk;
         mf   = (fw < 0) ? -fw : fw;
         case (mode)
            MODE_CENTRED: begin
               return DW'(cd >>> 1);
            end
            MODE_MINMOD: begin
               if (!same || mb == mf) return '0;
               return (mb < mf) ? DW'(bk) : DW'(fw);
            end
            MODE_MC: begin
               if (!same) return '0;
               m = ((cd < 0) ? -cd : cd) >>> 1;
               t = double_capped(mf);
               if (t < m) m = t;
               t = double_capped(mb);
               if (t < m) m = t;
               if (cd < 0) return DW'(-m);
               return DW'((m > SLOPE_MAX) ? SLOPE_MAX : m);
            end
            default: begin
               return '0;
            end
         endcase
      endfunction

      // An accepted sample; a full window yields the centre cell's slope.
      function void note_sample(logic [DW-1:0] s, logic line_start);
         if (line_start) cells_held = FILL_EMPTY;
         if (cells_held >= FILL_FULL)
            expected_slopes.push_back(limited_slope(longint'(signed'(left_cell)),
               longint'(signed'(centre_cell)), longint'(signed'(s))));
         left_cell   = centre_cell;
         centre_cell = s;
         if (cells_held < FILL_FULL) cells_held = cells_held + 1'b1;
      endfunction

      function void check_slope(logic [DW-1:0] got);
         logic [DW-1:0] want;
         if (expected_slopes.size() == 0) begin
            $error("slope: expected none, actual %h", got);
            errors++;
            return;
         end
         want = expected_slopes.pop_front();
         if (got !== want) begin
            $error("slope: expected %h, actual %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [DW-1:0] req_tdata;
   logic [0:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [DW-1:0] rsp_tdata;
   logic          csr_valid;
   logic          csr_ready;
   logic [1:0]    csr_data;

   slope_scoreboard slope_board;
   bit              steady;
   int              cycle_count;

   slope_limiter_window #(
      .DATA_WIDTH (DW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock with a 12 ns period.
   always #6 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side holds back at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 16);
   end

   // Handshake monitor: check results, record samples and mode writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) slope_board.check_slope(rsp_tdata);
         if (req_tvalid && req_tready) slope_board.note_sample(req_tdata, req_tuser[0]);
         if (csr_valid && csr_ready) slope_board.set_mode(limiter_mode_type'(csr_data));
      end
   end

   task automatic idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // Offer one sample item and wait until it is taken.
   task automatic send_sample(logic [DW-1:0] s, logic line_start);
      while (!steady && $urandom_range(0, 99) < 16) idle_sender(1);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= line_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending, wait for every expected slope, then let the pipeline empty.
   task automatic drain_and_settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (slope_board.expected_slopes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(limiter_mode_type m);
      drain_and_settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly smooth lines with random steps, some edge values and raw noise.
   function automatic logic [DW-1:0] next_sample(logic [DW-1:0] prev);
      int            pick;
      int            k;
      logic [DW-1:0] step;
      pick = $urandom_range(0, 99);
      if (pick < 10) return EDGE_VALUES[$urandom_range(0, 6)];
      if (pick < 25) return $urandom;
      k    = $urandom_range(0, 30);
      step = $urandom_range(0, 32'd1 << k);
      return $urandom_range(0, 1) ? prev + step : prev - step;
   endfunction

   initial begin
      logic [DW-1:0]    prev;
      limiter_mode_type phase_mode;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      steady      = 1'b0;
      cycle_count = 0;
      slope_board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines: minmod from reset, then centred, MC and zero slope.
      for (int i = 0; i < 24; i++) begin
         if (i == 6) write_mode(MODE_CENTRED);
         if (i == 12) write_mode(MODE_MC);
         if (i == 18) write_mode(MODE_ZERO);
         send_sample(DIRECTED[i], (i % 6 == 0) || (i == 22));
      end

      // Random phases, each under its own mode; one phase runs without gaps.
      prev = '0;
      for (int p = 0; p < PHASES; p++) begin
         phase_mode = (p < 4) ? limiter_mode_type'(p[1:0])
                              : limiter_mode_type'($urandom_range(0, 3));
         write_mode(phase_mode);
         steady = (p == 5);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            prev = next_sample(prev);
            send_sample(prev, (i == 0) || ($urandom_range(0, 99) < 4));
         end
      end

      drain_and_settle();
      steady = 1'b0;
      if (slope_board.errors == 0 && slope_board.expected_slopes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
src/slw_pkg.sv
src/slw_limiter.sv
src/slope_limiter_window.sv
src/slw_checker.sv
verif/tb_top.sv
